// ===== hw/rtl/qeb_pkg.sv =====
// ----------------------------------------------------------------------------
// qeb_pkg: shared types and constants of the quadrature encoder bank
// Holds the sizes, register indexes, step table and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package qeb_pkg;

    localparam int NUM_ENCODERS_DEF = 8;
    localparam int PIN_BITS         = 16;
    localparam int VAL_W            = 7;
    localparam int CHAN_W           = 4;
    localparam int IDX_OUT_W        = 5;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 7;

    localparam logic [VAL_W-1:0] START_POSITION = 7'd64;
    localparam logic [VAL_W-1:0] CEILING_RESET  = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIDI_CHANNEL    = 2'd0,
        REG_CONTROLLER_BASE = 2'd1,
        REG_VALUE_FLOOR     = 2'd2,
        REG_VALUE_CEILING   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } t_step;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] floor_val;
        logic [VAL_W-1:0] ceiling_val;
    } t_bounds;

    // Gray transition table, indexed by (old phase << 2) | new phase
    localparam t_step STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
    };

endpackage

`default_nettype wire

// ===== hw/rtl/qeb_phase_lanes.sv =====
// ----------------------------------------------------------------------------
// qeb_phase_lanes: per-encoder phase extraction and transition decode
// One lane per encoder: pick its pin pair, look up the Gray step.
// ----------------------------------------------------------------------------
`default_nettype none

module qeb_phase_lanes #(
    parameter int NUM_ENCODERS = qeb_pkg::NUM_ENCODERS_DEF
) (
    input  wire logic [qeb_pkg::PIN_BITS-1:0]   i_pins,
    input  wire logic [NUM_ENCODERS-1:0][1:0]   i_last_phase,
    output logic      [NUM_ENCODERS-1:0][1:0]   o_cur_phase,
    output logic      [NUM_ENCODERS-1:0]        o_moves,
    output logic      [NUM_ENCODERS-1:0]        o_up
);
    import qeb_pkg::*;

    for (genvar g = 0; g < NUM_ENCODERS; g++) begin : g_lane
        t_step lane_step;

        // encoders with no pins in the sample read phase zero
        if (2 * g + 1 < PIN_BITS) begin : g_pins
            assign o_cur_phase[g] = i_pins[2*g+1:2*g];
        end else begin : g_nopins
            assign o_cur_phase[g] = 2'b00;
        end

        assign lane_step  = STEP_TABLE[{i_last_phase[g], o_cur_phase[g]}];
        assign o_moves[g] = (lane_step != STEP_NONE);
        assign o_up[g]    = (lane_step == STEP_UP);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qeb_step_unit.sv =====
// ----------------------------------------------------------------------------
// qeb_step_unit: shared increment/decrement and clamp unit
// Apply one step of +1 or -1 to a position, then clamp to floor/ceiling.
// ----------------------------------------------------------------------------
`default_nettype none

module qeb_step_unit (
    input  wire logic [qeb_pkg::VAL_W-1:0] i_pos,
    input  wire logic                      i_up,
    input  wire qeb_pkg::t_bounds          i_bounds,
    output logic      [qeb_pkg::VAL_W-1:0] o_pos
);
    import qeb_pkg::*;

    logic signed [VAL_W+1:0] sum;
    logic signed [VAL_W+1:0] lo;
    logic signed [VAL_W+1:0] hi;

    always_comb begin
        sum = $signed({2'b00, i_pos}) + (i_up ? 9'sd1 : -9'sd1);
        lo  = $signed({2'b00, i_bounds.floor_val});
        hi  = $signed({2'b00, i_bounds.ceiling_val});
        // floor is checked first so it wins when the sum lies below the floor and above the ceiling
        priority if (sum < lo) begin
            o_pos = i_bounds.floor_val;
        end else if (sum > hi) begin
            o_pos = i_bounds.ceiling_val;
        end else begin
            o_pos = sum[VAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/quadrature_encoder_bank.sv =====
// ----------------------------------------------------------------------------
// quadrature_encoder_bank: x4 quadrature decoder bank with control changes
// Decodes A/B pin samples of up to 8 encoders into clamped positions.
// ----------------------------------------------------------------------------
// Each accepted beat on the input is one sample of all A/B pins (bit 2i+1 is
// phase A, bit 2i is phase B of encoder i). The first sample after reset only
// records the phases and emits nothing. For every later sample, all encoders
// are decoded in parallel at acceptance into a move mask; a sequencer then
// walks the encoders in ascending order through one shared step/clamp unit,
// updating each moving encoder's position and emitting one result beat per
// move, with last_of_run set on the final one. After a sample is accepted,
// the sequencer visits the encoders one by one up to the highest one that
// moved and then returns to idle; while the output register is full and not
// taken, the walk holds on a moving encoder. The input is not ready until
// the walk is done. Configuration writes must be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_bank #(
    parameter int NUM_ENCODERS = qeb_pkg::NUM_ENCODERS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [qeb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [qeb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // sample input
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [qeb_pkg::PIN_BITS-1:0]  i_pin_levels,
    // result output
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [qeb_pkg::IDX_OUT_W-1:0]      o_encoder_index,
    output logic [qeb_pkg::CHAN_W-1:0]         o_channel_out,
    output logic [qeb_pkg::VAL_W-1:0]          o_controller_number,
    output logic [qeb_pkg::VAL_W-1:0]          o_position_value,
    output logic                               o_last_of_run
);
    import qeb_pkg::*;

    localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    // configuration registers
    logic [CHAN_W-1:0] r_chan;
    logic [VAL_W-1:0]  r_base;
    t_bounds           r_bounds;

    // per-encoder state
    logic [NUM_ENCODERS-1:0][1:0]       r_phase;
    logic [VAL_W-1:0]                   r_pos [NUM_ENCODERS];
    logic                               r_primed;

    // walk state
    t_state                             r_state, n_state;
    logic [NUM_ENCODERS-1:0]            r_mask, n_mask;
    logic [NUM_ENCODERS-1:0]            r_up;
    logic [IDX_W-1:0]                   r_idx, n_idx;

    // output register
    logic                               r_ovalid, n_ovalid;
    logic [IDX_OUT_W-1:0]               r_oidx;
    logic [CHAN_W-1:0]                  r_ochan;
    logic [VAL_W-1:0]                   r_octrl;
    logic [VAL_W-1:0]                   r_oval;
    logic                               r_olast;

    // lane decode and shared unit
    logic [NUM_ENCODERS-1:0][1:0]       cur_phase;
    logic [NUM_ENCODERS-1:0]            moves;
    logic [NUM_ENCODERS-1:0]            up;
    logic [VAL_W-1:0]                   step_pos;
    logic                               in_fire;
    logic                               emit;
    logic [NUM_ENCODERS-1:0]            idx_bit;

    qeb_phase_lanes #(
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_lanes (
        .i_pins       (i_pin_levels),
        .i_last_phase (r_phase),
        .o_cur_phase  (cur_phase),
        .o_moves      (moves),
        .o_up         (up)
    );

    qeb_step_unit u_step (
        .i_pos    (r_pos[r_idx]),
        .i_up     (r_up[r_idx]),
        .i_bounds (r_bounds),
        .o_pos    (step_pos)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign in_fire = i_valid && o_ready;
    assign idx_bit = NUM_ENCODERS'(1) << r_idx;

    // sequencer: next state and walk controls
    always_comb begin
        n_state  = r_state;
        n_mask   = r_mask;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !i_ready;
        emit     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && r_primed) begin
                    n_state = ST_SCAN;
                    n_mask  = moves;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                if (r_mask == '0) begin
                    n_state = ST_IDLE;
                end else if (r_mask[r_idx]) begin
                    // hold this encoder until the output register frees up
                    if (!r_ovalid || i_ready) begin
                        emit     = 1'b1;
                        n_ovalid = 1'b1;
                        n_mask   = r_mask & ~idx_bit;
                        n_idx    = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan               <= '0;
            r_base               <= '0;
            r_bounds.floor_val   <= '0;
            r_bounds.ceiling_val <= CEILING_RESET;
            r_phase              <= '0;
            r_primed             <= 1'b0;
            r_mask               <= '0;
            r_idx                <= '0;
            r_ovalid             <= 1'b0;
            for (int i = 0; i < NUM_ENCODERS; i++) begin
                r_pos[i] <= START_POSITION;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_MIDI_CHANNEL:    r_chan <= i_cfg_wdata[CHAN_W-1:0];
                    REG_CONTROLLER_BASE: r_base <= i_cfg_wdata[VAL_W-1:0];
                    REG_VALUE_FLOOR:     r_bounds.floor_val <= i_cfg_wdata[VAL_W-1:0];
                    REG_VALUE_CEILING:   r_bounds.ceiling_val <= i_cfg_wdata[VAL_W-1:0];
                    default: ;
                endcase
            end
            // record every phase at acceptance; moves are already in the mask
            if (in_fire) begin
                r_phase  <= cur_phase;
                r_primed <= 1'b1;
                r_up     <= up;
            end
            r_mask   <= n_mask;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            if (emit) begin
                r_pos[r_idx] <= step_pos;
            end
        end
    end

    // output payload, loaded by the shared unit on each emitted move
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oidx  <= IDX_OUT_W'(r_idx);
            r_ochan <= r_chan;
            r_octrl <= r_base + VAL_W'(r_idx);
            r_oval  <= step_pos;
            r_olast <= ((r_mask & ~idx_bit) == '0);
        end
    end

    assign o_valid             = r_ovalid;
    assign o_encoder_index     = r_oidx;
    assign o_channel_out       = r_ochan;
    assign o_controller_number = r_octrl;
    assign o_position_value    = r_oval;
    assign o_last_of_run       = r_olast;

    // the walk only goes idle once every pending move is out
    a_idle_mask_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_mask == '0))
        else $error("idle with pending moves");

    // a beat that is not the last of its run leaves the walk still running
    a_run_continues : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_of_run) |-> (r_state == ST_SCAN))
        else $error("run ended without a last beat");

    // the priming sample never starts a walk
    a_prime_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_primed) |=> (r_state == ST_IDLE && r_primed))
        else $error("priming sample started a walk");

endmodule

`default_nettype wire
